/* rtl/core/wsr_pkg.sv */
// Shared types and register codes for the windowed sample reader.
// No dependencies; imported by the core top level.
`default_nettype none
package wsr_pkg;

  localparam logic [2:0] REG_SAMPLE_COUNT  = 3'd0;
  localparam logic [2:0] REG_WINDOW_START  = 3'd1;
  localparam logic [2:0] REG_WINDOW_END    = 3'd2;
  localparam logic [2:0] REG_REVERSE_PLAY  = 3'd3;
  localparam logic [2:0] REG_FADE_IN_LEN   = 3'd4;
  localparam logic [2:0] REG_FADE_OUT_LEN  = 3'd5;
  localparam logic [2:0] REG_LINEAR_INTERP = 3'd6;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // item held at the memory port
  typedef struct packed {
    logic        op;
    logic [15:0] waddr;
    logic [15:0] wvalue;
    logic [15:0] idx;
    logic [15:0] nxt;
    logic [15:0] frac;
    logic        fi_ap;
    logic        fo_ap;
    logic [31:0] fi_num;
    logic [31:0] fo_num;
  } mem_item_t;

  // read item waiting for its second sample
  typedef struct packed {
    logic signed [15:0] a;
    logic [15:0]        frac;
    logic               fi_ap;
    logic               fo_ap;
    logic [31:0]        fi_num;
    logic [31:0]        fo_num;
  } rd_item_t;

  // gain divider and interpolation stage
  typedef struct packed {
    logic               valid;
    logic               zero;
    logic               fi_ap;
    logic               fo_ap;
    logic signed [15:0] a;
    logic signed [15:0] b;
    logic [15:0]        frac;
    logic signed [16:0] diff;
    logic signed [32:0] v;
    logic [31:0]        fi_num;
    logic [31:0]        fo_num;
    logic [15:0]        fi_rem;
    logic [15:0]        fo_rem;
    logic [16:0]        fi_q;
    logic [16:0]        fo_q;
  } div_stage_t;

endpackage
`default_nettype wire

/* rtl/core/windowed_sample_reader_core.sv */
// Windowed sample reader: sample memory, window clamp, interpolation, fades.
// Depends on wsr_pkg and wsr_ram.
`default_nettype none
// Usage:
//   in_* carries items: in_tuser = op (1 read, 0 write). A write stores
//   write_value at write_addr and gives no result; a read gives one
//   out_tdata item, the faded and interpolated sample at position.
//   cfg_we/cfg_index/cfg_wdata write the setup registers while idle.
// Memory port: a read makes two accesses of the single memory port (current
//   and next sample), so the memory stage takes no new item while a read is
//   on its first access; a write makes one access.
// Pipeline: input register, memory port stage, one capture stage, divider input
//   register, 17 gain-divider steps (one quotient bit each), gain select,
//   multiply, and the output register with combinational rounding in front.
// Reset clears all valid bits and the setup registers (linear_interp to 1);
//   the sample memory is not cleared and reads undefined until written.
// Stall: an output register plus a skid register absorb a stalled
//   receiver; the pipeline freezes once the skid register fills, and
//   in_tready drops.
module windowed_sample_reader_core #(
  parameter int MAX_SAMPLES = 65536,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [15:0] write_addr, [31:16] write_value, [63:32] position
  input  wire logic [63:0] in_tdata,
  // [0] op
  input  wire logic        in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [15:0] sample_out
  output logic      [15:0] out_tdata,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [16:0] cfg_wdata
);
  import wsr_pkg::*;

  localparam int AW = $clog2(MAX_SAMPLES);
  localparam logic [24:0] MAX_L = 25'(MAX_SAMPLES);
  localparam int NDIV = 17;

  // setup registers
  logic [16:0] sample_count_r;
  logic [15:0] window_start_r, window_end_r, fade_in_len_r, fade_out_len_r;
  logic        reverse_play_r, linear_interp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_count_r  <= '0;
      window_start_r  <= '0;
      window_end_r    <= '0;
      reverse_play_r  <= 1'b0;
      fade_in_len_r   <= '0;
      fade_out_len_r  <= '0;
      linear_interp_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SAMPLE_COUNT:  sample_count_r  <= cfg_wdata;
        REG_WINDOW_START:  window_start_r  <= cfg_wdata[15:0];
        REG_WINDOW_END:    window_end_r    <= cfg_wdata[15:0];
        REG_REVERSE_PLAY:  reverse_play_r  <= cfg_wdata[0];
        REG_FADE_IN_LEN:   fade_in_len_r   <= cfg_wdata[15:0];
        REG_FADE_OUT_LEN:  fade_out_len_r  <= cfg_wdata[15:0];
        REG_LINEAR_INTERP: linear_interp_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // window geometry, recomputed every cycle from the setup registers
  logic [16:0] tot, tot_m1, len, fo_p1;
  logic [15:0] cs, ce1, ce, start;
  logic [15:0] cs_r, ce_r, span_r, start_r;
  logic [31:0] maxp_r;
  logic        zero_r;

  always_comb begin
    tot    = ({8'b0, sample_count_r} > MAX_L) ? MAX_L[16:0] : sample_count_r;
    tot_m1 = tot - 17'd1;
    cs     = ({1'b0, window_start_r} < tot_m1) ? window_start_r : tot_m1[15:0];
    ce1    = (window_end_r < cs) ? cs : window_end_r;
    ce     = ({1'b0, ce1} > tot_m1) ? tot_m1[15:0] : ce1;
    len    = {1'b0, ce} - {1'b0, cs} + 17'd1;
    fo_p1  = {1'b0, fade_out_len_r} + 17'd1;
    start  = (len > fo_p1) ? 16'(len - fo_p1) : 16'd0;
  end

  always_ff @(posedge clk) begin
    cs_r    <= cs;
    ce_r    <= ce;
    span_r  <= ce - cs;
    maxp_r  <= {16'(ce - cs), 16'b0};
    start_r <= start;
    zero_r  <= (tot == 17'd0) || (len <= 17'd1);
  end

  // pipeline enable: freeze while the skid register is full
  logic sk_v_r;
  logic en;
  assign en = !sk_v_r;

  // input register
  logic        s1_v_r;
  logic        s1_op_r;
  logic [63:0] s1_d_r;

  // memory port stage
  logic      s2_v_r, s2_ph_r;
  mem_item_t s2_r, s2_nxt;
  logic      s2_load;

  assign s2_load   = !s2_v_r || (s2_r.op == OP_WRITE) || s2_ph_r;
  assign in_tready = en && (!s1_v_r || s2_load);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en && s2_load) begin
      s1_v_r <= in_tvalid && in_tready;
    end else if (in_tvalid && in_tready) begin
      s1_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_op_r <= in_tuser;
      s1_d_r  <= in_tdata;
    end
  end

  // clamp the position and prepare indexes and fade terms
  logic [31:0] pos, p;
  always_comb begin
    pos           = s1_d_r[63:32];
    p             = (pos > maxp_r) ? maxp_r : pos;
    s2_nxt.op     = s1_op_r;
    s2_nxt.waddr  = s1_d_r[15:0];
    s2_nxt.wvalue = s1_d_r[31:16];
    s2_nxt.idx    = p[31:16];
    s2_nxt.nxt    = (p[31:16] == span_r) ? p[31:16] : p[31:16] + 16'd1;
    s2_nxt.frac   = p[15:0];
    s2_nxt.fi_ap  = (fade_in_len_r != 16'd0) && (p < {fade_in_len_r, 16'b0});
    s2_nxt.fo_ap  = (fade_out_len_r != 16'd0) && (p >= {start_r, 16'b0});
    s2_nxt.fi_num = p;
    s2_nxt.fo_num = maxp_r - p;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r  <= 1'b0;
      s2_ph_r <= 1'b0;
    end else if (en) begin
      if (s2_load) begin
        s2_v_r  <= s1_v_r;
        s2_ph_r <= 1'b0;
      end else begin
        s2_ph_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && s2_load) begin
      s2_r <= s2_nxt;
    end
  end

  // memory access
  logic [15:0]            x_idx, m_idx;
  logic [AW+15:0]         m_ext, w_ext;
  logic [AW-1:0]          ram_addr;
  logic [SAMPLE_BITS-1:0] ram_wdata, ram_rdata;
  logic                   ram_we;
  logic [15:0]            rd16;

  always_comb begin
    x_idx    = s2_ph_r ? s2_r.nxt : s2_r.idx;
    m_idx    = reverse_play_r ? ce_r - x_idx : cs_r + x_idx;
    m_ext    = {{AW{1'b0}}, m_idx};
    w_ext    = {{AW{1'b0}}, s2_r.waddr};
    ram_addr = (s2_r.op == OP_WRITE) ? w_ext[AW-1:0] : m_ext[AW-1:0];
    ram_we   = en && s2_v_r && (s2_r.op == OP_WRITE) && ({9'b0, s2_r.waddr} < MAX_L);
  end

  generate
    if (SAMPLE_BITS < 16) begin : g_narrow
      assign ram_wdata = s2_r.wvalue[15:16-SAMPLE_BITS];
      assign rd16      = {ram_rdata, {(16-SAMPLE_BITS){1'b0}}};
    end else if (SAMPLE_BITS == 16) begin : g_exact
      assign ram_wdata = s2_r.wvalue;
      assign rd16      = ram_rdata;
    end else begin : g_wide
      assign ram_wdata = {{(SAMPLE_BITS-16){s2_r.wvalue[15]}}, s2_r.wvalue};
      assign rd16      = ram_rdata[15:0];
    end
  endgenerate

  wsr_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(MAX_SAMPLES)
  ) u_mem (
    .clk  (clk),
    .re   (en),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  // first sample captured; second sample arrives during this stage
  logic     s3_v_r;
  rd_item_t s3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en) begin
      s3_v_r <= s2_v_r && (s2_r.op == OP_READ) && s2_ph_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en && s2_ph_r) begin
      s3_r.a      <= $signed(rd16);
      s3_r.frac   <= s2_r.frac;
      s3_r.fi_ap  <= s2_r.fi_ap;
      s3_r.fo_ap  <= s2_r.fo_ap;
      s3_r.fi_num <= s2_r.fi_num;
      s3_r.fo_num <= s2_r.fo_num;
    end
  end

  // gain dividers, one quotient bit per stage, interpolation alongside
  div_stage_t dv_r [0:NDIV];
  div_stage_t dv_in;

  always_comb begin
    dv_in        = '0;
    dv_in.valid  = s3_v_r;
    dv_in.zero   = zero_r;
    dv_in.fi_ap  = s3_r.fi_ap;
    dv_in.fo_ap  = s3_r.fo_ap;
    dv_in.a      = s3_r.a;
    dv_in.b      = linear_interp_r ? $signed(rd16) : s3_r.a;
    dv_in.frac   = s3_r.frac;
    dv_in.fi_num = s3_r.fi_num;
    dv_in.fo_num = s3_r.fo_num;
    dv_in.fi_rem = {1'b0, s3_r.fi_num[31:17]};
    dv_in.fo_rem = {1'b0, s3_r.fo_num[31:17]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r[0].valid <= 1'b0;
    end else if (en) begin
      dv_r[0] <= dv_in;
    end
  end

  genvar k;
  generate
    for (k = 0; k < NDIV; k++) begin : g_div
      div_stage_t  nx;
      logic [16:0] fi_t, fo_t;

      always_comb begin
        nx   = dv_r[k];
        fi_t = {dv_r[k].fi_rem, dv_r[k].fi_num[NDIV-1-k]};
        fo_t = {dv_r[k].fo_rem, dv_r[k].fo_num[NDIV-1-k]};
        if (fi_t >= {1'b0, fade_in_len_r}) begin
          nx.fi_rem           = 16'(fi_t - {1'b0, fade_in_len_r});
          nx.fi_q[NDIV-1-k]   = 1'b1;
        end else begin
          nx.fi_rem = fi_t[15:0];
        end
        if (fo_t >= {1'b0, fade_out_len_r}) begin
          nx.fo_rem           = 16'(fo_t - {1'b0, fade_out_len_r});
          nx.fo_q[NDIV-1-k]   = 1'b1;
        end else begin
          nx.fo_rem = fo_t[15:0];
        end
        if (k == 0) begin
          nx.diff = 17'(dv_r[k].b) - 17'(dv_r[k].a);
        end
        if (k == 1) begin
          nx.v = 33'(dv_r[k].diff * $signed({1'b0, dv_r[k].frac}));
        end
        if (k == 2) begin
          nx.v = dv_r[k].v + (33'(dv_r[k].a) <<< 16);
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          dv_r[k+1].valid <= 1'b0;
        end else if (en) begin
          dv_r[k+1] <= nx;
        end
      end
    end
  endgenerate

  // gain select
  logic               e1_v_r, e1_zero_r;
  logic signed [32:0] e1_v_val_r;
  logic [16:0]        e1_gain_r;
  logic [16:0]        g0, g1, g2;

  always_comb begin
    g0 = 17'h10000;
    g1 = (dv_r[NDIV].fi_ap && dv_r[NDIV].fi_q < g0) ? dv_r[NDIV].fi_q : g0;
    g2 = (dv_r[NDIV].fo_ap && dv_r[NDIV].fo_q < g1) ? dv_r[NDIV].fo_q : g1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1_v_r <= 1'b0;
    end else if (en) begin
      e1_v_r <= dv_r[NDIV].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e1_zero_r  <= dv_r[NDIV].zero;
      e1_v_val_r <= dv_r[NDIV].v;
      e1_gain_r  <= g2;
    end
  end

  // apply gain
  logic               e2_v_r, e2_zero_r;
  logic signed [50:0] e2_prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e2_v_r <= 1'b0;
    end else if (en) begin
      e2_v_r <= e1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e2_zero_r <= e1_zero_r;
      e2_prod_r <= 51'(e1_v_val_r * $signed({1'b0, e1_gain_r}));
    end
  end

  // round half up, saturate
  logic signed [50:0] rnd;
  logic signed [18:0] r;
  logic [15:0]        res;
  logic               push;

  always_comb begin
    rnd = e2_prod_r + 51'sd2147483648;
    r   = 19'(rnd >>> 32);
    if (e2_zero_r) begin
      res = 16'd0;
    end else if (r > 19'sd32767) begin
      res = 16'h7FFF;
    end else if (r < -19'sd32768) begin
      res = 16'h8000;
    end else begin
      res = r[15:0];
    end
    push = en && e2_v_r;
  end

  // output register and skid
  logic        out_v_r;
  logic [15:0] out_d_r, sk_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      sk_v_r  <= 1'b0;
    end else if (out_tready || !out_v_r) begin
      if (sk_v_r) begin
        out_v_r <= 1'b1;
        sk_v_r  <= 1'b0;
      end else begin
        out_v_r <= push;
      end
    end else if (push) begin
      sk_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_tready || !out_v_r) begin
      out_d_r <= sk_v_r ? sk_d_r : res;
    end else if (push) begin
      sk_d_r <= res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;

endmodule
`default_nettype wire

/* rtl/core/wsr_ram.sv */
// Generic single-port RAM, registered read with read enable.
// No dependencies.
`default_nettype none
module wsr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     re,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule
`default_nettype wire

/* tb/testbench.sv */
// Self-checking testbench for windowed_sample_reader_core: loads sample memory,
// plays it back under several windows and fades, predicts each read result.
// Depends on wsr_pkg and the core RTL.
module testbench;
  import wsr_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [16:0] cfg_wdata;

  windowed_sample_reader_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  localparam int LATENCY = 24;
  localparam int CYCLE_LIMIT = 400000;

  // shadow of the block's memory and registers
  logic signed [15:0] shadow_mem [0:65535];
  logic [16:0] r_count;
  logic [15:0] r_wstart, r_wend, r_fin, r_fout;
  logic        r_rev, r_interp;

  logic signed [15:0] expected_samples [$];
  int errors;
  int reads_checked;
  int cycles;
  int burst_left;
  int gap_left;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver stall pattern: long ready stretches, then bursts of stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      case ((cycles / 300) % 3)
        0: out_tready <= 1'b1;
        1: out_tready <= ($urandom_range(0, 3) != 0);
        default: out_tready <= ($urandom_range(0, 9) > 6);
      endcase
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_samples.size() == 0) begin
        report_mismatch("unexpected sample_out", $signed(out_tdata), 0);
      end else begin
        logic signed [15:0] want;
        want = expected_samples.pop_front();
        if ($signed(out_tdata) !== want)
          report_mismatch("sample_out", $signed(out_tdata), want);
        reads_checked++;
      end
    end
  end

  function automatic logic [15:0] map_idx(input longint pidx, input longint cs,
                                           input longint ce);
    if (pidx > ce - cs) pidx = ce - cs;
    return r_rev ? 16'(ce - pidx) : 16'(cs + pidx);
  endfunction

  function automatic logic signed [15:0] playback_sample(input logic [31:0] position);
    longint total, cs, ce, len, p, maxp, gain, g, fstart, i, fr, nx;
    longint a, b, v, r;
    total = r_count > 65536 ? 65536 : r_count;
    if (total == 0) return 16'sd0;
    cs = r_wstart < total - 1 ? r_wstart : total - 1;
    ce = r_wend;
    if (ce < cs) ce = cs;
    if (ce > total - 1) ce = total - 1;
    len = ce - cs + 1;
    if (len <= 1) return 16'sd0;
    p = position;
    maxp = (len - 1) <<< 16;
    if (p > maxp) p = maxp;
    i = p >>> 16;
    fr = p & 16'hFFFF;
    a = shadow_mem[map_idx(i, cs, ce)];
    if (r_interp) begin
      nx = i + 1 < len ? i + 1 : len - 1;
      b = shadow_mem[map_idx(nx, cs, ce)];
      v = a * 65536 + (b - a) * fr;
    end else begin
      v = a * 65536;
    end
    gain = 65536;
    if (r_fin > 0 && p < (longint'(r_fin) <<< 16)) begin
      g = p / r_fin;
      if (g < gain) gain = g;
    end
    if (r_fout > 0) begin
      fstart = len > r_fout + 1 ? len - r_fout - 1 : 0;
      if (p >= (fstart <<< 16)) begin
        g = (maxp - p) / r_fout;
        if (g < gain) gain = g;
      end
    end
    r = (v * gain + (longint'(1) <<< 31)) >>> 32;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return 16'(r);
  endfunction

  task automatic set_reg(input logic [2:0] idx, input logic [16:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_SAMPLE_COUNT:  r_count = val;
      REG_WINDOW_START:  r_wstart = val[15:0];
      REG_WINDOW_END:    r_wend = val[15:0];
      REG_REVERSE_PLAY:  r_rev = val[0];
      REG_FADE_IN_LEN:   r_fin = val[15:0];
      REG_FADE_OUT_LEN:  r_fout = val[15:0];
      REG_LINEAR_INTERP: r_interp = val[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic setup(input int count, input int ws, input int we, input bit rev,
                       input int fin, input int fout, input bit interp);
    set_reg(REG_SAMPLE_COUNT, 17'(count));
    set_reg(REG_WINDOW_START, 17'(ws));
    set_reg(REG_WINDOW_END, 17'(we));
    set_reg(REG_REVERSE_PLAY, 17'(rev));
    set_reg(REG_FADE_IN_LEN, 17'(fin));
    set_reg(REG_FADE_OUT_LEN, 17'(fout));
    set_reg(REG_LINEAR_INTERP, 17'(interp));
  endtask

  // send one item, with bursty random gaps in front of it; valid stays up
  // after acceptance until the next item or an idle stretch replaces it
  task automatic send_item(input logic op, input logic [15:0] addr,
                           input logic [15:0] value, input logic [31:0] position);
    if (burst_left == 0) begin
      gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      burst_left = $urandom_range(1, 20);
      if (gap_left > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap_left) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {position, value, addr};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (op == OP_WRITE) begin
      shadow_mem[addr] = value;
    end else begin
      expected_samples.push_back(playback_sample(position));
    end
  endtask

  task automatic write_sample(input int addr, input logic [15:0] value);
    send_item(OP_WRITE, 16'(addr), value, $urandom());
  endtask

  task automatic read_at(input logic [31:0] position);
    send_item(OP_READ, 16'($urandom()), 16'($urandom()), position);
  endtask

  // hold until every expected result is in and the pipeline is empty
  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  // fill indexes lo..hi so every read inside the window hits written memory
  task automatic load_range(input int lo, input int hi);
    for (int k = lo; k <= hi; k++)
      write_sample(k, 16'($urandom()));
  endtask

  task automatic test_directed();
    // empty memory and one-sample windows give zero without touching memory
    read_at(32'h0001_8000);
    drain();
    setup(1, 0, 0, 0, 0, 0, 1);
    read_at(32'hFFFF_FFFF);
    write_sample(0, 16'h7FFF);
    write_sample(1, 16'h8000);
    write_sample(2, 16'h7FFF);
    write_sample(3, 16'h0000);
    write_sample(65534, 16'h4000);
    write_sample(65535, 16'h8000);
    drain();
    setup(4, 0, 3, 0, 0, 0, 1);
    read_at(32'h0000_0000);
    read_at(32'h0000_8000);
    read_at(32'h0000_FFFF);
    read_at(32'h0002_8000);
    read_at(32'hFFFF_FFFF);
    drain();
    setup(4, 0, 3, 1, 0, 0, 0);
    read_at(32'h0000_8000);
    read_at(32'h0003_0000);
    drain();
    // start at the last index, end below start, maximal fades
    setup(65536, 65535, 0, 0, 65535, 65535, 1);
    read_at(32'h0001_0000);
    drain();
    setup(4, 1, 65535, 0, 2, 2, 1);
    read_at(32'h0000_0000);
    read_at(32'h0000_C000);
    read_at(32'h0001_4000);
    read_at(32'h0002_0000);
    drain();
    setup(65536, 65534, 65535, 0, 1, 65535, 1);
    read_at(32'h0000_8000);
    drain();
  endtask

  task automatic test_random_playback();
    for (int ph = 0; ph < 9; ph++) begin
      int count, ws, we, lo, hi, reads, n;
      count = (ph == 8) ? 65536 : (ph == 7 ? 131071 : $urandom_range(2, 600));
      ws = $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535) : $urandom_range(0, 500);
      we = $urandom_range(0, 3) == 0 ? 65535 : ws + $urandom_range(0, 120);
      if (we > 65535) we = 65535;
      setup(count, ws, we, $urandom_range(0, 1),
            $urandom_range(0, 1) ? $urandom_range(0, 60) : (ph == 3 ? 65535 : 0),
            $urandom_range(0, 1) ? $urandom_range(0, 60) : (ph == 4 ? 65535 : 0),
            $urandom_range(0, 1));
      // compute the clamped window and fill it
      n = count > 65536 ? 65536 : count;
      lo = ws < n - 1 ? ws : n - 1;
      hi = we < lo ? lo : we;
      if (hi > n - 1) hi = n - 1;
      if (hi - lo > 150) hi = lo + 150;
      // keep the window small so only written entries are read
      set_reg(REG_WINDOW_END, 17'(hi));
      load_range(lo, hi);
      reads = 125;
      for (int k = 0; k < reads; k++) begin
        logic [31:0] pos;
        case ($urandom_range(0, 5))
          0: pos = $urandom();
          1: pos = {16'(hi - lo), 16'h0000};
          default: pos = {16'($urandom_range(0, hi - lo + 1)), 16'($urandom())};
        endcase
        if ($urandom_range(0, 7) == 0) begin
          // overwrite inside the window with a new value
          write_sample($urandom_range(lo, hi), 16'($urandom()));
        end
        read_at(pos);
      end
      // also a write to the top address, which may lie outside the window
      write_sample(65535, 16'($urandom()));
      drain();
    end
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    cycles = 0;
    errors = 0;
    reads_checked = 0;
    burst_left = 0;
    gap_left = 0;
    r_count = 0; r_wstart = 0; r_wend = 0; r_rev = 0;
    r_fin = 0; r_fout = 0; r_interp = 1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_playback();
    drain();
    $display("Covered window clamps, forward and reverse playback, fades and");
    $display("interpolation; %0d read results checked", reads_checked);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
